>>> rtl/phe_pkg.sv
// Shared types and constants of the Horner polynomial evaluator.
package phe_pkg;

  localparam int COEF_W = 32;
  localparam int FRAC_W = 16;
  localparam int IDX_W  = 7;
  localparam int PROD_W = 2 * COEF_W;
  localparam int SHR_W  = PROD_W - FRAC_W;
  localparam int SUM_W  = SHR_W + 1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [IDX_W-1:0]         idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic start;
    logic load_p;
    logic mul_en;
    logic add_en;
  } mac_ctl_t;

endpackage

>>> rtl/phe_if.sv
// Valid/ready channel interfaces for command items and result items.
interface phe_in_if;
  import phe_pkg::*;

  logic  valid;
  logic  ready;
  logic  cmd;
  idx_t  coef_index;
  coef_t coef_value;
  coef_t x_value;

  modport source(output valid, cmd, coef_index, coef_value, x_value, input ready);
  modport sink(input valid, cmd, coef_index, coef_value, x_value, output ready);
endinterface

interface phe_out_if;
  import phe_pkg::*;

  logic  valid;
  logic  ready;
  coef_t poly_value;
  logic  overflow;

  modport source(output valid, poly_value, overflow, input ready);
  modport sink(input valid, poly_value, overflow, output ready);
endinterface

>>> rtl/phe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module phe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/phe_mac.sv
// Horner step datapath: registered multiply, then shift, add and saturate.
module phe_mac (
  input  logic             clk,
  input  phe_pkg::mac_ctl_t ctl,
  input  phe_pkg::coef_t   x_in,
  input  phe_pkg::coef_t   coef,
  input  logic             coef_ok,
  output phe_pkg::coef_t   poly,
  output logic             ovf
);
  import phe_pkg::*;

  coef_t                    x_r;
  coef_t                    p_r;
  logic                     ovf_r;
  logic signed [PROD_W-1:0] prod_r;
  coef_t                    coef_eff;
  logic signed [SUM_W-1:0]  sum;
  logic                     sat_hi;
  logic                     sat_lo;
  coef_t                    p_sat;

  // A power beyond the store reads as zero.
  assign coef_eff = coef_ok ? coef : '0;

  always_comb begin
    sum = $signed({prod_r[PROD_W-1], prod_r[PROD_W-1:FRAC_W]})
        + $signed({{(SUM_W-COEF_W){coef_eff[COEF_W-1]}}, coef_eff});
    sat_hi = !sum[SUM_W-1] && (sum[SUM_W-2:COEF_W-1] != '0);
    sat_lo = sum[SUM_W-1] && !(&sum[SUM_W-2:COEF_W-1]);
    if (sat_hi) begin
      p_sat = {1'b0, {(COEF_W-1){1'b1}}};
    end else if (sat_lo) begin
      p_sat = {1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      p_sat = sum[COEF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x_r   <= x_in;
      ovf_r <= 1'b0;
    end
    if (ctl.load_p) begin
      p_r <= coef_eff;
    end
    if (ctl.mul_en) begin
      prod_r <= p_r * x_r;
    end
    if (ctl.add_en) begin
      p_r   <= p_sat;
      ovf_r <= ovf_r | sat_hi | sat_lo;
    end
  end

  assign poly = p_r;
  assign ovf  = ovf_r;

endmodule

>>> rtl/phe_seq.sv
// Sequencer: clearing pass, coefficient writes and the Horner walk over the store.
module phe_seq #(
  parameter int COEF_DEPTH = 128,
  parameter int ADDR_W     = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_cmd,
  input  phe_pkg::idx_t      in_coef_index,
  input  phe_pkg::coef_t     in_coef_value,
  output logic               in_ready,
  input  phe_pkg::idx_t      degree,
  input  logic               out_free,
  output logic               res_load,
  output logic               ram_we,
  output logic [ADDR_W-1:0]  ram_waddr,
  output phe_pkg::coef_t     ram_wdata,
  output logic               ram_re,
  output logic [ADDR_W-1:0]  ram_raddr,
  output logic               coef_ok,
  output phe_pkg::mac_ctl_t  ctl
);
  import phe_pkg::*;

  seq_state_t        state_r, state_nxt;
  idx_t              k_r, k_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic              rd_ok_r;
  idx_t              rd_k;
  logic              rd_in_range;
  logic              wr_in_range;

  assign rd_k        = (state_r == ST_IDLE) ? degree : k_r - idx_t'(1);
  assign rd_in_range = 32'(rd_k) < COEF_DEPTH;
  assign wr_in_range = 32'(in_coef_index) < COEF_DEPTH;
  assign ram_raddr   = ADDR_W'(rd_k);
  assign coef_ok     = rd_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_ok_r <= rd_in_range;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    clr_nxt   = clr_r;
    in_ready  = 1'b0;
    res_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ADDR_W'(in_coef_index);
    ram_wdata = in_coef_value;
    ram_re    = 1'b0;
    ctl       = '0;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(COEF_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_WRITE) begin
            ram_we = wr_in_range;
          end else begin
            ram_re    = 1'b1;
            ctl.start = 1'b1;
            k_nxt     = degree;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        ctl.load_p = 1'b1;
        if (k_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          k_nxt     = k_r - idx_t'(1);
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        ctl.mul_en = 1'b1;
        state_nxt  = ST_ADD;
      end
      ST_ADD: begin
        ctl.add_en = 1'b1;
        if (k_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          k_nxt     = k_r - idx_t'(1);
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/polynomial_horner_evaluator.sv
// Top level of the Horner polynomial evaluator over a coefficient RAM.
//
//   channel  dir  payload                                   handshake
//   in_if    in   cmd, coef_index, coef_value, x_value      valid/ready
//   out_if   out  poly_value, overflow                      valid/ready
//   cfg      in   cfg_wr_data (degree)                      cfg_wr_en
//
// A write item is stored in the RAM as it is accepted. An evaluate item holds
// off the next item until its result is passed on: each coefficient goes through the
// registered multiplier and then the shift/add/saturate step.
// After reset a clearing pass writes zero to all COEF_DEPTH RAM entries,
// one per cycle, with in_if.ready low until the pass is done.
// A finished result waits in the sequencer while the output register is full.
module polynomial_horner_evaluator #(
  parameter int COEF_DEPTH = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  phe_in_if.sink        in_if,
  phe_out_if.source     out_if,
  input  logic          cfg_wr_en,
  input  phe_pkg::idx_t cfg_wr_data
);
  import phe_pkg::*;

  localparam int ADDR_W = $clog2(COEF_DEPTH);

  idx_t              degree_r;
  logic              out_valid_r, out_valid_nxt;
  coef_t             poly_r;
  logic              ovf_r;
  logic              res_load;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  coef_t             ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [COEF_W-1:0] ram_rdata;
  logic              coef_ok;
  mac_ctl_t          ctl;
  coef_t             mac_poly;
  logic              mac_ovf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        degree_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid_nxt = res_load | (out_valid_r & ~out_if.ready);

  always_ff @(posedge clk) begin
    if (res_load) begin
      poly_r <= mac_poly;
      ovf_r  <= mac_ovf;
    end
  end

  phe_seq #(
    .COEF_DEPTH (COEF_DEPTH),
    .ADDR_W     (ADDR_W)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_if.valid),
    .in_cmd        (in_if.cmd),
    .in_coef_index (in_if.coef_index),
    .in_coef_value (in_if.coef_value),
    .in_ready      (in_if.ready),
    .degree        (degree_r),
    .out_free      (~out_valid_r | out_if.ready),
    .res_load      (res_load),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .coef_ok       (coef_ok),
    .ctl           (ctl)
  );

  phe_ram #(
    .WIDTH (COEF_W),
    .DEPTH (COEF_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  phe_mac u_mac (
    .clk     (clk),
    .ctl     (ctl),
    .x_in    (in_if.x_value),
    .coef    (ram_rdata),
    .coef_ok (coef_ok),
    .poly    (mac_poly),
    .ovf     (mac_ovf)
  );

  assign out_if.valid      = out_valid_r;
  assign out_if.poly_value = poly_r;
  assign out_if.overflow   = ovf_r;

endmodule

>>> verif/polynomial_horner_evaluator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the Horner polynomial evaluator.
module polynomial_horner_evaluator_tb;
  import phe_pkg::*;

  localparam int STORE_DEPTH = 128;
  localparam int TOTAL_ITEMS = 1420;
  localparam int CALM_ITEMS = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;
  localparam longint LIMIT_NS = 64'd25_000_000;
  localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

  class poly_scoreboard;
    typedef struct {
      coef_t value;
      logic  overflow;
    } poly_result_t;

    coef_t        coefs [STORE_DEPTH];
    idx_t         degree;
    poly_result_t results_due [$];
    int           errors;

    function new();
      foreach (coefs[i]) coefs[i] = '0;
      degree = '0;
      errors = 0;
    endfunction

    function void flag_error(string what);
      if (errors < REPORT_LIMIT) $display("%0t: %s", $time, what);
      errors++;
    endfunction

    // Updates the coefficient copy, or folds the stored polynomial at x by
    // Horner's rule with saturation at every step.
    function void note_command(logic cmd, idx_t index, coef_t coef, coef_t x);
      logic signed [63:0] acc;
      logic signed [63:0] prod;
      logic signed [63:0] sum;
      poly_result_t       res;
      int                 k;
      if (cmd == CMD_WRITE) begin
        coefs[index] = coef;
      end else begin
        acc = coefs[degree];
        res.overflow = 1'b0;
        for (k = degree; k > 0; k--) begin
          prod = acc * x;
          sum = (prod >>> FRAC_W) + coefs[k-1];
          if (sum > Q_MAX) begin
            sum = Q_MAX;
            res.overflow = 1'b1;
          end else if (sum < Q_MIN) begin
            sum = Q_MIN;
            res.overflow = 1'b1;
          end
          acc = sum;
        end
        res.value = acc[COEF_W-1:0];
        results_due.push_back(res);
      end
    endfunction

    function void check_value(coef_t value, logic overflow);
      poly_result_t want;
      if (results_due.size() == 0) begin
        flag_error($sformatf("unexpected result poly_value %h overflow %b", value, overflow));
      end else begin
        want = results_due.pop_front();
        if (value !== want.value || overflow !== want.overflow)
          flag_error($sformatf("poly_value %h overflow %b, expected %h %b",
                               value, overflow, want.value, want.overflow));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  idx_t cfg_wr_data;

  phe_in_if  in_if();
  phe_out_if out_if();

  polynomial_horner_evaluator #(.COEF_DEPTH(STORE_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  poly_scoreboard board = new();

  int in_gap_pct = 0;
  int out_stall_pct = 0;
  int stall_left = 0;
  int items_sent = 0;
  bit calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check every accepted item and stall in short bursts.
  always @(posedge clk) begin
    if (out_if.valid && out_if.ready) board.check_value(out_if.poly_value, out_if.overflow);
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(1, 100) <= out_stall_pct) begin
      stall_left = $urandom_range(0, 2);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_item(logic cmd, idx_t index, coef_t coef, coef_t x);
    if (!calm && $urandom_range(1, 100) <= in_gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.cmd        <= cmd;
    in_if.coef_index <= index;
    in_if.coef_value <= coef;
    in_if.x_value    <= x;
    do @(posedge clk); while (!in_if.ready);
    board.note_command(cmd, index, coef, x);
    items_sent++;
  endtask

  // Unused fields of each command carry random junk.
  task automatic write_coef(idx_t index, coef_t coef);
    send_item(CMD_WRITE, index, coef, $urandom);
  endtask

  task automatic eval_at(coef_t x);
    send_item(CMD_EVAL, idx_t'($urandom), $urandom, x);
  endtask

  // The degree only changes once the block has drained.
  task automatic set_degree(idx_t d);
    in_if.valid <= 1'b0;
    while (board.results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.degree = d;
  endtask

  function automatic coef_t rand_coef();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return coef_t'($urandom_range(0, 32'h80000)) - 32'sh40000;
    endcase
  endfunction

  // Most points lie within about 1.5 so that long polynomials stay in range.
  function automatic coef_t rand_x();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'sh00010000 : 32'shffff0000;
      2:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return coef_t'($urandom_range(0, 32'h30000)) - 32'sh18000;
    endcase
  endfunction

  initial begin : stimulus
    int phase;
    int count;
    int d;
    int r;
    int k;
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_WRITE;
    in_if.coef_index = '0;
    in_if.coef_value = '0;
    in_if.x_value    = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, starting at degree zero on a freshly cleared store.
    eval_at(32'sh7fffffff);
    write_coef(idx_t'(0), 32'sh7fffffff);
    write_coef(idx_t'(STORE_DEPTH-1), 32'sh80000000);
    eval_at(32'sh80000000);
    set_degree(idx_t'(STORE_DEPTH-1));
    eval_at('0);
    eval_at(32'sh00020000);
    set_degree(idx_t'(1));
    write_coef(idx_t'(1), 32'sh7fffffff);
    eval_at(32'sh7fffffff);
    eval_at(32'sh80000000);
    eval_at(32'sh00010000);
    eval_at(32'shffff0000);
    // The negative x nearest zero checks that the shift rounds down.
    eval_at(32'shffffffff);
    write_coef(idx_t'(1), 32'sh80000000);
    write_coef(idx_t'(0), 32'sh80000000);
    eval_at(32'sh00010000);
    eval_at(32'sh00000001);
    write_coef(idx_t'(1), 32'sh00018000);
    write_coef(idx_t'(0), 32'shfffe8000);
    eval_at(32'shfffe0000);

    // Random part: each phase picks a degree, usually loads a full
    // polynomial and then mixes evaluations with edits.
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      if (phase == 0) d = STORE_DEPTH - 1;
      else if (phase == 1) d = 0;
      else if ($urandom_range(0, 4) == 0) d = $urandom_range(0, STORE_DEPTH - 1);
      else d = $urandom_range(0, 8);
      set_degree(idx_t'(d));
      case ($urandom_range(0, 2))
        0: in_gap_pct = 0;
        1: in_gap_pct = 15;
        default: in_gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: out_stall_pct = 0;
        1: out_stall_pct = 15;
        default: out_stall_pct = 40;
      endcase
      if ($urandom_range(0, 3) != 0)
        for (k = 0; k <= d; k++) write_coef(idx_t'(k), rand_coef());
      count = $urandom_range(10, 40);
      repeat (count) begin
        r = $urandom_range(0, 99);
        if (r < 55) eval_at(rand_x());
        else if (r < 85) write_coef(idx_t'($urandom_range(0, d)), rand_coef());
        else write_coef(idx_t'($urandom), rand_coef());
        calm = (items_sent >= TOTAL_ITEMS - CALM_ITEMS);
      end
      phase++;
    end

    in_if.valid <= 1'b0;
    while (board.results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0)
      $display("polynomial_horner_evaluator_tb: clean");
    else
      $display("polynomial_horner_evaluator_tb: errors");
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("polynomial_horner_evaluator_tb: errors");
    $finish;
  end

endmodule
